>>> src/bleafp_pkg.sv
// ----------------------------------------------------------------------------
// bleafp_pkg
// Shared types and constants of the advertising data filter.
// ----------------------------------------------------------------------------
package bleafp_pkg;

  // Structure types that the parser looks at.
  localparam logic [7:0] KIND_MFG       = 8'hff;
  localparam logic [7:0] KIND_APPEAR    = 8'h19;
  localparam logic [7:0] KIND_UUID_INC  = 8'h06;
  localparam logic [7:0] KIND_UUID_CMPL = 8'h07;

  localparam logic [15:0] APPEAR_MASK = 16'hffc0;
  localparam logic [15:0] APPEAR_VAL  = 16'h03c0;

  localparam logic [15:0] COMPANY_ID_RST = 16'd1363;

  // Manufacturer data must open with these bytes after the company id.
  localparam logic [7:0] MFG_PREFIX [4] = '{8'h01, 8'h00, 8'h03, 8'h7e};

  // Target service UUID; list entries carry it byte-reversed.
  localparam logic [7:0] TARGET_UUID [16] = '{
    8'hab, 8'h7d, 8'he9, 8'hbe, 8'h89, 8'hfe, 8'h49, 8'had,
    8'h82, 8'h8f, 8'h11, 8'h8f, 8'h09, 8'hdf, 8'h7f, 8'hd2
  };

  // Structure lengths at which the prefix and the zero run fit completely.
  localparam logic [7:0] LEN_PREFIX_MIN   = 8'd7;
  localparam logic [7:0] LEN_PAIRABLE_MIN = 8'd19;

  typedef struct packed {
    logic [7:0] adv_byte;
    logic       last_byte;
  } item_t;

  // Flags committed by complete structures, maker in the lowest bit.
  typedef struct packed {
    logic service;
    logic appearance;
    logic pairable;
    logic prefix;
    logic maker;
  } flags_t;

  // Result beat, candidate in the lowest bit, padded to a byte.
  typedef struct packed {
    logic [1:0] pad;
    logic       service_hit;
    logic       appearance_hit;
    logic       pairable_seen;
    logic       prefix_seen;
    logic       maker_seen;
    logic       candidate;
  } result_t;

endpackage

>>> src/bleafp_in_stage.sv
// ----------------------------------------------------------------------------
// bleafp_in_stage
// Input register: holds one payload beat until the parser consumes it.
// ----------------------------------------------------------------------------
module bleafp_in_stage (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  bleafp_pkg::item_t item_i,
  input  logic            pop_i,
  output logic            valid_o,
  output bleafp_pkg::item_t item_o
);
  import bleafp_pkg::*;

  logic  valid_q, valid_d;
  item_t item_q;

  always_comb begin
    valid_d = valid_q;
    if (pop_i) begin
      valid_d = 1'b0;
    end
    if (push_i) begin
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

>>> src/bleafp_parse.sv
// ----------------------------------------------------------------------------
// bleafp_parse
// Length-type-value walker: one payload byte per accepted step, flags
// committed when a structure completes, cleared after the last byte.
// ----------------------------------------------------------------------------
module bleafp_parse (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  bleafp_pkg::item_t  item_i,
  input  logic [15:0]        company_id_i,
  output bleafp_pkg::flags_t flags_o
);
  import bleafp_pkg::*;

  logic [7:0] pos_q, pos_d;
  logic [7:0] length_q, length_d;
  logic [7:0] kind_q, kind_d;
  logic       halted_q, halted_d;
  logic [7:0] held_q, held_d;
  logic       maker_q, maker_d;
  logic       prefix_q, prefix_d;
  logic       zeros_q, zeros_d;
  logic       appear_q, appear_d;
  logic       chunk_q, chunk_d;
  logic       service_q, service_d;
  flags_t     flags_q, flags_d, flags_nx;

  logic [7:0] b;
  logic [7:0] k;
  logic [3:0] c;
  logic [1:0] pfx_idx;
  logic       is_uuid;
  logic       now;
  logic       commit;

  assign b       = item_i.adv_byte;
  assign k       = pos_q - 8'd2;
  assign c       = k[3:0];
  assign pfx_idx = k[1:0] - 2'd2;
  assign is_uuid = (kind_q == KIND_UUID_INC) || (kind_q == KIND_UUID_CMPL);
  assign now     = ((c == 4'd0) || chunk_q) && (b == TARGET_UUID[4'd15 - c]);

  always_comb begin
    pos_d     = pos_q;
    length_d  = length_q;
    kind_d    = kind_q;
    halted_d  = halted_q;
    held_d    = held_q;
    maker_d   = maker_q;
    prefix_d  = prefix_q;
    zeros_d   = zeros_q;
    appear_d  = appear_q;
    chunk_d   = chunk_q;
    service_d = service_q;
    flags_nx  = flags_q;
    commit    = 1'b0;

    if (!halted_q) begin
      if (pos_q == 8'd0) begin
        if (b == 8'd0) begin
          halted_d = 1'b1;
        end else begin
          length_d = b;
          pos_d    = 8'd1;
        end
      end else if (pos_q == 8'd1) begin
        // A type-only structure returns to the length byte without a commit.
        kind_d    = b;
        maker_d   = 1'b0;
        prefix_d  = 1'b0;
        zeros_d   = 1'b0;
        appear_d  = 1'b0;
        service_d = 1'b0;
        chunk_d   = 1'b1;
        pos_d     = (length_q == 8'd1) ? 8'd0 : 8'd2;
      end else begin
        if (kind_q == KIND_MFG) begin
          if (k == 8'd0) begin
            held_d = b;
          end else if (k == 8'd1) begin
            maker_d  = ({b, held_q} == company_id_i);
            prefix_d = maker_d;
            zeros_d  = maker_d;
          end else if (maker_q) begin
            if ((k < 8'd6) && (b != MFG_PREFIX[pfx_idx])) begin
              prefix_d = 1'b0;
            end
            if ((k >= 8'd12) && (k < 8'd18) && (b != 8'd0)) begin
              zeros_d = 1'b0;
            end
          end
        end else if (kind_q == KIND_APPEAR) begin
          if (k == 8'd0) begin
            held_d = b;
          end else if (k == 8'd1) begin
            appear_d = (({b, held_q} & APPEAR_MASK) == APPEAR_VAL);
          end
        end else if (is_uuid) begin
          // Each 16-byte chunk is compared on its own; a match latches.
          if (c == 4'd15) begin
            if (now) begin
              service_d = 1'b1;
            end
            chunk_d = 1'b1;
          end else begin
            chunk_d = now;
          end
        end

        if (pos_q >= length_q) begin
          commit = 1'b1;
          pos_d  = 8'd0;
        end else begin
          pos_d = pos_q + 8'd1;
        end
      end
    end

    if (commit) begin
      if (kind_q == KIND_MFG) begin
        if (maker_d) begin
          flags_nx.maker    = 1'b1;
          flags_nx.prefix   = prefix_d && (length_q >= LEN_PREFIX_MIN);
          flags_nx.pairable = flags_nx.prefix && zeros_d &&
                              (length_q >= LEN_PAIRABLE_MIN);
        end
      end else if (kind_q == KIND_APPEAR) begin
        if (appear_d) begin
          flags_nx.appearance = 1'b1;
        end
      end else if (is_uuid) begin
        if (service_d) begin
          flags_nx.service = 1'b1;
        end
      end
    end

    flags_d = flags_nx;

    // The payload ends here: start the next one from scratch.
    if (item_i.last_byte) begin
      pos_d     = 8'd0;
      length_d  = 8'd0;
      kind_d    = 8'd0;
      halted_d  = 1'b0;
      held_d    = 8'd0;
      maker_d   = 1'b0;
      prefix_d  = 1'b0;
      zeros_d   = 1'b0;
      appear_d  = 1'b0;
      chunk_d   = 1'b1;
      service_d = 1'b0;
      flags_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= 8'd0;
      length_q  <= 8'd0;
      kind_q    <= 8'd0;
      halted_q  <= 1'b0;
      held_q    <= 8'd0;
      maker_q   <= 1'b0;
      prefix_q  <= 1'b0;
      zeros_q   <= 1'b0;
      appear_q  <= 1'b0;
      chunk_q   <= 1'b1;
      service_q <= 1'b0;
      flags_q   <= '0;
    end else if (step_i) begin
      pos_q     <= pos_d;
      length_q  <= length_d;
      kind_q    <= kind_d;
      halted_q  <= halted_d;
      held_q    <= held_d;
      maker_q   <= maker_d;
      prefix_q  <= prefix_d;
      zeros_q   <= zeros_d;
      appear_q  <= appear_d;
      chunk_q   <= chunk_d;
      service_q <= service_d;
      flags_q   <= flags_d;
    end
  end

  assign flags_o = flags_nx;

endmodule

>>> src/bleafp_out_stage.sv
// ----------------------------------------------------------------------------
// bleafp_out_stage
// Result register: builds the result beat and holds it until taken.
// ----------------------------------------------------------------------------
module bleafp_out_stage (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_i,
  input  bleafp_pkg::flags_t   flags_i,
  input  logic                 ready_i,
  output logic                 free_o,
  output logic                 valid_o,
  output bleafp_pkg::result_t  result_o
);
  import bleafp_pkg::*;

  logic    valid_q, valid_d;
  result_t result_q, result_d;

  assign free_o = !valid_q || ready_i;

  always_comb begin
    result_d.pad            = 2'b00;
    result_d.candidate      = flags_i.prefix || flags_i.pairable || flags_i.service ||
                              (flags_i.appearance && flags_i.maker);
    result_d.maker_seen     = flags_i.maker;
    result_d.prefix_seen    = flags_i.prefix;
    result_d.pairable_seen  = flags_i.pairable;
    result_d.appearance_hit = flags_i.appearance;
    result_d.service_hit    = flags_i.service;
    valid_d = load_i ? 1'b1 : (valid_q && !ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_d;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = result_q;

endmodule

>>> src/ble_adv_filter_parser_top.sv
// ----------------------------------------------------------------------------
// ble_adv_filter_parser_top
// Advertising payload filter: walks length-type-value structures byte by
// byte and reports maker, prefix, pairable, appearance and service matches.
// ----------------------------------------------------------------------------
//  Channel   Direction  Payload
//  s_axis    in         tdata[7:0] adv_byte, tlast last_byte
//  m_axis    out        tdata[0] candidate .. [5] service_hit, one beat per payload
//  cfg       in         cfg_data_i[15:0] company_id
//
//  Throughput is one payload byte per cycle while no last byte waits on a stalled
//  result beat; each result passes the input register, then the result register.
//  Reset clears the parse state and sets company_id to 1363.
//  A stalled result beat only holds back bytes marked last; other bytes keep
//  flowing into the parser unless a last byte waits ahead of them.
module ble_adv_filter_parser_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] adv_byte
  input  logic        s_axis_tlast,   // last_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [0] candidate, [1] maker_seen, [2] prefix_seen,
                                      // [3] pairable_seen, [4] appearance_hit,
                                      // [5] service_hit, [7:6] zero
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i      // [15:0] company_id
);
  import bleafp_pkg::*;

  logic        in_valid;
  item_t       in_item;
  item_t       s_item;
  logic        out_free;
  logic        step;
  flags_t      flags;
  result_t     result;
  logic [15:0] company_id_q;

  assign s_item.adv_byte  = s_axis_tdata;
  assign s_item.last_byte = s_axis_tlast;

  assign step          = in_valid && (!in_item.last_byte || out_free);
  assign s_axis_tready = !in_valid || step;
  assign cfg_ready_o   = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      company_id_q <= COMPANY_ID_RST;
    end else if (cfg_valid_i) begin
      company_id_q <= cfg_data_i;
    end
  end

  bleafp_in_stage u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (s_axis_tvalid && s_axis_tready),
    .item_i  (s_item),
    .pop_i   (step),
    .valid_o (in_valid),
    .item_o  (in_item)
  );

  bleafp_parse u_parse (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (step),
    .item_i       (in_item),
    .company_id_i (company_id_q),
    .flags_o      (flags)
  );

  bleafp_out_stage u_out_stage (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (step && in_item.last_byte),
    .flags_i  (flags),
    .ready_i  (m_axis_tready),
    .free_o   (out_free),
    .valid_o  (m_axis_tvalid),
    .result_o (result)
  );

  assign m_axis_tdata = result;

endmodule
